// File: hdl/fcfs_pkg.sv
// Shared types and codes for the FCFS scheduler.
package fcfs_pkg;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_DONE = 2'd1,
    ST_DROP = 2'd2
  } status_t;

  typedef enum logic {
    MODE_ARRIVAL = 1'b0,
    MODE_TICK    = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  job_id;
    logic [15:0] burst_len;
  } job_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  done_id;
    logic [31:0] completion_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        server_busy;
    logic [4:0]  queued;
  } res_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] burst;
    logic [31:0] arrival;
  } entry_t;

  typedef struct packed {
    logic        pop;
    logic        finish;
    logic        busy_next;
    logic [7:0]  id;
    logic [31:0] ctime;
    logic [31:0] tat;
    logic [31:0] wt;
  } srv_stat_t;

endpackage

// File: hdl/fcfs_cell.sv
// One slot of the wait queue; the row shifts toward the head on a pop.
module fcfs_cell import fcfs_pkg::*; (
  input  logic   clk,
  input  logic   shift,
  input  logic   load,
  input  entry_t din,
  input  entry_t nbr,
  output entry_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= nbr;
    end else if (load) begin
      q <= din;
    end
  end

endmodule

// File: hdl/fcfs_server.sv
// Running job, time counter and completion figures.
module fcfs_server import fcfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic        head_avail,
  input  entry_t      head,
  output logic        busy,
  output logic [31:0] time_now,
  output srv_stat_t   stat
);

  logic [31:0] time_next;
  logic [7:0]  run_id;
  logic [15:0] run_burst;
  logic [31:0] run_arrival;
  logic [15:0] run_left;

  logic        take;
  logic        cur_busy;
  logic [15:0] left_eff;
  logic [15:0] left_dec;
  logic [15:0] burst_eff;
  logic [31:0] arr_eff;
  logic [7:0]  id_eff;
  logic [31:0] ta;
  logic [31:0] burst_ext;
  logic        finish;

  always_comb begin
    take      = !busy && head_avail;
    cur_busy  = busy || take;
    left_eff  = take ? head.burst : run_left;
    burst_eff = take ? head.burst : run_burst;
    arr_eff   = take ? head.arrival : run_arrival;
    id_eff    = take ? head.id : run_id;
    left_dec  = (left_eff != 16'd0) ? left_eff - 16'd1 : 16'd0;
    time_next = (time_now == '1) ? time_now : time_now + 32'd1;
    finish    = cur_busy && (left_dec == 16'd0);
    ta        = time_next - arr_eff;
    burst_ext = {16'd0, burst_eff};

    stat.pop       = tick && take;
    stat.finish    = finish;
    stat.busy_next = cur_busy && !finish;
    stat.id        = id_eff;
    stat.ctime     = time_next;
    stat.tat       = ta;
    // clamp when saturated time makes turnaround shorter than the burst
    stat.wt        = (ta >= burst_ext) ? ta - burst_ext : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now    <= '0;
      busy        <= 1'b0;
      run_id      <= '0;
      run_burst   <= '0;
      run_arrival <= '0;
      run_left    <= '0;
    end else if (tick) begin
      time_now <= time_next;
      busy     <= cur_busy && !finish;
      if (take) begin
        run_id      <= head.id;
        run_burst   <= head.burst;
        run_arrival <= head.arrival;
      end
      if (cur_busy) begin
        run_left <= left_dec;
      end
    end
  end

endmodule

// File: hdl/fcfs_process_scheduler.sv
// Top level of the first-come-first-served single-server scheduler.
//
// Each transaction on the job channel is an arrival (queued behind earlier jobs,
// stamped with the current time, or dropped with status "dropped" when all
// QUEUE_DEPTH slots are full) or a time tick (an idle server takes the queue
// head, time advances and saturates, the running job counts down and is
// reported on completion). Every job transaction yields exactly one result
// transaction. The queue is a row of QUEUE_DEPTH cells that shift one place
// toward the head on each pop, the server does one decrement per tick, and the
// result sits in an output register, so a new item is taken every cycle as
// long as the result side keeps up.
module fcfs_process_scheduler import fcfs_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          push;
  logic          drop;
  logic          tick;
  logic          busy;
  entry_t        new_entry;
  entry_t        cells [QUEUE_DEPTH];
  srv_stat_t     srv;
  res_t          res_next;
  logic [31:0]   time_now_q;

  assign job_ready = !res_valid || res_ready;
  assign accept    = job_valid && job_ready;
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign push      = accept && (job.mode == MODE_ARRIVAL) && !full;
  assign drop      = accept && (job.mode == MODE_ARRIVAL) && full;
  assign tick      = accept && (job.mode == MODE_TICK);

  // an arrival is stamped with the current time and a zero burst is stored as one; it never ticks
  always_comb begin
    new_entry.id      = job.job_id;
    new_entry.burst   = (job.burst_len == 16'd0) ? 16'd1 : job.burst_len;
    new_entry.arrival = time_now_q;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cells[i+1];
    end
    fcfs_cell u_cell (
      .clk   (clk),
      .shift (srv.pop),
      .load  (push && (count == CW'(i))),
      .din   (new_entry),
      .nbr   (nbr),
      .q     (cells[i])
    );
  end

  fcfs_server u_server (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .head_avail (count != '0),
    .head       (cells[0]),
    .busy       (busy),
    .time_now   (time_now_q),
    .stat       (srv)
  );

  always_comb begin
    count_next = count;
    if (push) begin
      count_next = count + CW'(1);
    end else if (srv.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    res_next = '0;
    res_next.status      = ST_NONE;
    res_next.server_busy = busy;
    res_next.queued      = 5'(count_next);
    if (drop) begin
      res_next.status  = ST_DROP;
      res_next.done_id = job.job_id;
    end else if (tick) begin
      res_next.server_busy = srv.busy_next;
      if (srv.finish) begin
        res_next.status          = ST_DONE;
        res_next.done_id         = srv.id;
        res_next.completion_time = srv.ctime;
        res_next.turnaround      = srv.tat;
        res_next.waiting         = srv.wt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    accept && job.mode == MODE_ARRIVAL && !full |=> res.status != ST_DROP)
    else $error("arrival dropped with room in queue");

  a_tick_serves: assert property (@(posedge clk) disable iff (rst)
    tick && count != '0 |=> res.server_busy || res.status == ST_DONE)
    else $error("server idle with jobs waiting after a tick");

  a_tat_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_DONE |-> res.turnaround <= res.completion_time)
    else $error("turnaround exceeds completion time");

endmodule

// File: sim/fcfs_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the FCFS scheduler: predicts each result and compares it field by field.
module fcfs_result_checker import fcfs_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  logic job_ready,
  input  job_t job,
  input  logic res_valid,
  input  logic res_ready,
  input  res_t res,
  output int   fail_count,
  output int   pending
);

  // Scheduler shadow state
  logic [31:0] sched_time;
  entry_t      waiting_jobs[$];
  logic        srv_busy;
  entry_t      srv_job;
  logic [15:0] srv_left;

  res_t        expected_res[$];

  function automatic res_t schedule_step(input job_t j);
    res_t        r;
    entry_t      e;
    logic [31:0] ta;
    r = '0;
    r.status = ST_NONE;
    if (j.mode == MODE_ARRIVAL) begin
      if (waiting_jobs.size() >= QUEUE_DEPTH) begin
        r.status = ST_DROP;
        r.done_id = j.job_id;
      end else begin
        e.id = j.job_id;
        // store a zero burst as one tick
        e.burst = (j.burst_len == 16'd0) ? 16'd1 : j.burst_len;
        e.arrival = sched_time;
        waiting_jobs.insert(waiting_jobs.size(), e);
      end
    end else begin
      if (!srv_busy && waiting_jobs.size() > 0) begin
        srv_job = waiting_jobs.pop_front();
        srv_left = srv_job.burst;
        srv_busy = 1'b1;
      end
      if (sched_time != 32'hFFFF_FFFF) sched_time = sched_time + 32'd1;
      if (srv_busy) begin
        if (srv_left > 16'd0) srv_left = srv_left - 16'd1;
        if (srv_left == 16'd0) begin
          ta = sched_time - srv_job.arrival;
          r.status = ST_DONE;
          r.done_id = srv_job.id;
          r.completion_time = sched_time;
          r.turnaround = ta;
          // saturate waiting at zero when the turnaround is shorter than the burst
          r.waiting = (ta >= {16'd0, srv_job.burst}) ? ta - {16'd0, srv_job.burst} : 32'd0;
          srv_busy = 1'b0;
        end
      end
    end
    r.server_busy = srv_busy;
    r.queued = 5'(waiting_jobs.size());
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    if (rst) begin
      sched_time = '0;
      waiting_jobs.delete();
      srv_busy = 1'b0;
      srv_job = '0;
      srv_left = '0;
      expected_res.delete();
      pending = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h", $time, res);
          fail_count++;
        end else begin
          exp_r = expected_res.pop_front();
          check_field("status", 32'(exp_r.status), 32'(res.status));
          check_field("done_id", 32'(exp_r.done_id), 32'(res.done_id));
          check_field("completion_time", exp_r.completion_time, res.completion_time);
          check_field("turnaround", exp_r.turnaround, res.turnaround);
          check_field("waiting", exp_r.waiting, res.waiting);
          check_field("server_busy", 32'(exp_r.server_busy), 32'(res.server_busy));
          check_field("queued", 32'(exp_r.queued), 32'(res.queued));
        end
      end
      if (job_valid && job_ready) begin
        expected_res.insert(expected_res.size(), schedule_step(job));
      end
      pending = expected_res.size();
    end
  end

endmodule

// File: sim/fcfs_process_scheduler_test.sv
`timescale 1ns / 100ps
// Testbench top for the FCFS scheduler: clock, reset, stimulus, receiver stalls and verdict.
module fcfs_process_scheduler_test;
  import fcfs_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  localparam int RANDOM_ITEMS   = 920;
  localparam int DRAIN_TICKS    = 150;
  localparam int TAIL_ARRIVALS  = 10;
  localparam int HOLD_AT        = 250;
  localparam int PAUSE_AT       = 600;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum int {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic job_valid = 1'b0;
  logic job_ready;
  job_t job       = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  int fail_count;
  int pending;
  int hold_reqs   = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fcfs_process_scheduler #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  fcfs_result_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic job_t arrival_job(input logic [7:0] id, input logic [15:0] burst);
    job_t j;
    j.mode = MODE_ARRIVAL;
    j.job_id = id;
    j.burst_len = burst;
    return j;
  endfunction

  // id and burst ride along on a tick but must be ignored
  function automatic job_t tick_job(input logic [7:0] id, input logic [15:0] junk);
    job_t j;
    j.mode = MODE_TICK;
    j.job_id = id;
    j.burst_len = junk;
    return j;
  endfunction

  function automatic job_t random_job(input int arrival_pct);
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(99) < arrival_pct) begin
      if (pick < 5) return arrival_job(8'($urandom), 16'd0);
      if (pick < 85) return arrival_job(8'($urandom), 16'($urandom_range(1, 6)));
      return arrival_job(8'($urandom), 16'($urandom_range(7, 40)));
    end
    return tick_job(8'($urandom), 16'($urandom));
  endfunction

  // Hold valid and payload until the transaction is taken
  task automatic offer_job(input job_t j);
    job_valid <= 1'b1;
    job <= j;
    @(posedge clk);
    while (!job_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if ($urandom_range(3) != 0) begin
      job_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    job_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int burst_left;
    int arrival_pct;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle tick, zero burst, ignored tick payload, full queue and drops
    offer_job(tick_job(8'h00, 16'h0000));
    offer_job(arrival_job(8'h00, 16'h0000));
    offer_job(tick_job(8'hFF, 16'hFFFF));
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
      offer_job(arrival_job((i == QUEUE_DEPTH) ? 8'hFF : 8'(8'h10 + i),
                            (i == 0) ? 16'd2 : 16'd1));
    end
    offer_job(tick_job(8'h5A, 16'h8001));
    offer_job(tick_job(8'hA5, 16'h7FFE));
    offer_job(arrival_job(8'h55, 16'd3));
    offer_job(arrival_job(8'hFE, 16'd1));

    // Random bursts with a varying arrival mix
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(2))
        0:       arrival_pct = 20;
        1:       arrival_pct = 50;
        default: arrival_pct = 80;
      endcase
      burst_left = $urandom_range(1, 30);
      while (burst_left > 0 && sent < RANDOM_ITEMS) begin
        offer_job(random_job(arrival_pct));
        sent++;
        burst_left--;
        if (sent == HOLD_AT) hold_reqs++;
        if (sent == PAUSE_AT) wait_for_drain();
      end
      sender_gap();
    end

    // Empty the queue, then send long bursts that exercise the upper burst bits
    for (int i = 0; i < DRAIN_TICKS; i++) begin
      offer_job(tick_job(8'($urandom), 16'($urandom)));
      if ($urandom_range(7) == 0) sender_gap();
    end
    for (int i = 0; i < TAIL_ARRIVALS; i++) begin
      offer_job(arrival_job(8'($urandom), 16'($urandom) | 16'h8000));
      offer_job(arrival_job(8'($urandom), 16'($urandom) & 16'h7FFF));
    end
    repeat (3) offer_job(tick_job(8'($urandom), 16'($urandom)));

    job_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("fcfs_process_scheduler_test passed");
    end else begin
      $display("fcfs_process_scheduler_test failed");
    end
    $finish;
  end

  // Receiver: stall pattern changes every so often; long hold-off on request
  initial begin
    rx_pattern_t pattern;
    int          pattern_left;
    int          holds_done;
    int unsigned rx_phase;
    pattern = RX_OPEN;
    pattern_left = 0;
    holds_done = 0;
    rx_phase = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      if (pattern_left == 0) begin
        pattern = rx_pattern_t'($urandom_range(3));
        pattern_left = $urandom_range(20, 300);
      end
      pattern_left--;
      rx_phase++;
      case (pattern)
        RX_OPEN:   res_ready <= 1'b1;
        RX_MOSTLY: res_ready <= ($urandom_range(3) != 0);
        RX_SPARSE: res_ready <= ($urandom_range(3) == 0);
        default:   res_ready <= (rx_phase[1:0] != 2'd0);
      endcase
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (job_valid && job_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("fcfs_process_scheduler_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
